// File: rtl/sdr_pkg.sv
// Shared widths, fixed-point constants and helper functions for the sine unit.
`timescale 1ns / 1ps

package sdr_pkg;

	localparam int ANGLE_W = 32;
	localparam int SINE_W  = 32;
	localparam int MAG_W   = 32;
	localparam int RAD_W   = 35;
	localparam int Z_W     = 36;
	localparam int XY_W    = 33;
	localparam int PROD_W  = 63;

	localparam int ANGLE_FRAC_BITS_DEF = 16;
	localparam int SINE_FRAC_BITS_DEF  = 30;
	localparam int CORDIC_STAGES_DEF   = 24;

	localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
	localparam logic [63:0] TWOPI_Q60  = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] PI_Q32     = (PI_Q60 + (64'd1 << 27)) >> 28;
	localparam logic [63:0] TWOPI_Q32  = (TWOPI_Q60 + (64'd1 << 27)) >> 28;
	localparam logic [63:0] HALFPI_Q32 = (PI_Q60 + (64'd1 << 28)) >> 29;
	localparam logic [63:0] DEG2RAD_Q36 = ((PI_Q60 / 64'd180) + (64'd1 << 23)) >> 24;
	localparam logic [31:0] GAIN_Q30   = 32'd652032874;

	typedef struct packed {
		logic valid;
		logic zero;
		logic neg;
	} sdr_ctl_t;

	function automatic logic [63:0] pi_qf(input int afb);
		return (PI_Q60 + (64'd1 << (59 - afb))) >> (60 - afb);
	endfunction

	function automatic logic [63:0] twopi_qf(input int afb);
		return (TWOPI_Q60 + (64'd1 << (59 - afb))) >> (60 - afb);
	endfunction

	function automatic logic [63:0] full_deg(input int afb);
		return 64'd360 << afb;
	endfunction

	function automatic logic [63:0] half_deg(input int afb);
		return 64'd180 << afb;
	endfunction

	// Number of conditional subtractions that bring any magnitude up to 2^31
	// below the smaller of the two moduli.
	function automatic int reduce_steps(input int afb);
		logic [63:0] m;
		int n;
		m = twopi_qf(afb);
		n = 0;
		for (int k = 0; k < 40; k++) begin
			if ((m << k) <= 64'h8000_0000) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

	// Arctangent of 2^-idx in Q32. Past index ten the cubic term is below
	// half an LSB, so the entry is the power of two itself.
	function automatic logic [31:0] atan_q32(input int unsigned idx);
		logic [31:0] v;
		case (idx)
			0:       v = 32'd3373259426;
			1:       v = 32'd1991351318;
			2:       v = 32'd1052175346;
			3:       v = 32'd534100635;
			4:       v = 32'd268086748;
			5:       v = 32'd134174063;
			6:       v = 32'd67103403;
			7:       v = 32'd33553749;
			8:       v = 32'd16777131;
			9:       v = 32'd8388597;
			10:      v = 32'd4194303;
			default: v = 32'd1 << (6'd32 - 6'(idx));
		endcase
		return v;
	endfunction

endpackage

// File: rtl/sdr_reduce.sv
// Angle magnitude and modulo reduction by pipelined compare-subtract, plus zero detection.
`timescale 1ns / 1ps

module sdr_reduce #(
	parameter int ANGLE_FRAC_BITS = sdr_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                degree_mode,
	input  logic                                in_valid,
	input  logic signed [sdr_pkg::ANGLE_W-1:0] angle,
	output sdr_pkg::sdr_ctl_t                   ctl_o,
	output logic [sdr_pkg::MAG_W-1:0]           mag_o
);

	localparam int STEPS = sdr_pkg::reduce_steps(ANGLE_FRAC_BITS);
	localparam int PAD_W = 64 - sdr_pkg::MAG_W;
	localparam logic [63:0] MOD_DEG  = sdr_pkg::full_deg(ANGLE_FRAC_BITS);
	localparam logic [63:0] MOD_RAD  = sdr_pkg::twopi_qf(ANGLE_FRAC_BITS);
	localparam logic [63:0] HALF_DEG = sdr_pkg::half_deg(ANGLE_FRAC_BITS);
	localparam logic [63:0] HALF_RAD = sdr_pkg::pi_qf(ANGLE_FRAC_BITS);

	// Index 0 is the magnitude stage, index k+1 follows subtraction step k.
	logic [sdr_pkg::MAG_W-1:0] mag_s [0:STEPS];
	sdr_pkg::sdr_ctl_t         ctl_s [0:STEPS];
	logic [sdr_pkg::MAG_W-1:0] mag_sz;
	sdr_pkg::sdr_ctl_t         ctl_sz;
	logic [63:0]               chk_mag;
	logic [63:0]               chk_half;
	logic                      chk_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].valid <= in_valid;
			ctl_s[0].zero  <= 1'b0;
			ctl_s[0].neg   <= angle[sdr_pkg::ANGLE_W-1];
		end
	end

	// Two's complement magnitude; the most negative angle gives 2^31, which fits.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s[0] <= angle[sdr_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int SH = STEPS - 1 - k;
		localparam logic [63:0] SUB_DEG = MOD_DEG << SH;
		localparam logic [63:0] SUB_RAD = MOD_RAD << SH;

		logic [63:0] sub;
		logic        take;

		always_comb begin
			sub  = degree_mode ? SUB_DEG : SUB_RAD;
			take = {{PAD_W{1'b0}}, mag_s[k]} >= sub;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[k+1] <= take ? (mag_s[k] - sub[sdr_pkg::MAG_W-1:0]) : mag_s[k];
			end
		end
	end

	// A remainder within one LSB of zero or of a half turn forces an exact zero.
	always_comb begin
		chk_mag  = {{PAD_W{1'b0}}, mag_s[STEPS]};
		chk_half = degree_mode ? HALF_DEG : HALF_RAD;
		chk_hit  = (chk_mag <= 64'd1) ||
			((chk_mag + 64'd1 >= chk_half) && (chk_mag <= chk_half + 64'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sz <= '0;
		end else if (en) begin
			ctl_sz.valid <= ctl_s[STEPS].valid;
			ctl_sz.neg   <= ctl_s[STEPS].neg;
			ctl_sz.zero  <= chk_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_sz <= mag_s[STEPS];
		end
	end

	assign ctl_o = ctl_sz;
	assign mag_o = mag_sz;

endmodule

// File: rtl/sdr_convert.sv
// Conversion of the reduced angle to Q32 radians and folding into the CORDIC range.
`timescale 1ns / 1ps

module sdr_convert #(
	parameter int ANGLE_FRAC_BITS = sdr_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             degree_mode,
	input  sdr_pkg::sdr_ctl_t                ctl_i,
	input  logic [sdr_pkg::MAG_W-1:0]        mag_i,
	output sdr_pkg::sdr_ctl_t                ctl_o,
	output logic signed [sdr_pkg::Z_W-1:0]   z_o
);

	localparam int PW = sdr_pkg::PROD_W;
	localparam int RW = sdr_pkg::RAD_W;
	localparam logic [30:0]   DEG2RAD  = sdr_pkg::DEG2RAD_Q36[30:0];
	localparam logic [PW-1:0] DEG_RND  = PW'(64'd1 << (ANGLE_FRAC_BITS + 3));
	localparam int            DEG_SH   = ANGLE_FRAC_BITS + 4;
	localparam int            RAD_SH   = 32 - ANGLE_FRAC_BITS;
	localparam logic [RW-1:0] PI_R     = sdr_pkg::PI_Q32[RW-1:0];
	localparam logic [RW-1:0] TWOPI_R  = sdr_pkg::TWOPI_Q32[RW-1:0];
	localparam logic [RW-1:0] HALFPI_R = sdr_pkg::HALFPI_Q32[RW-1:0];

	sdr_pkg::sdr_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [PW-1:0]     prod_s1;
	logic [RW-1:0]     rad_s2, rad_s3, rad_s4;
	logic signed [sdr_pkg::Z_W-1:0] z_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.zero  <= ctl_s2.zero;
			// Folding past a half turn mirrors the angle and flips the sign.
			ctl_s3.neg   <= ctl_s2.neg ^ (rad_s2 > PI_R);
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (degree_mode) begin
				prod_s1 <= PW'(mag_i) * PW'(DEG2RAD);
			end else begin
				prod_s1 <= PW'(mag_i) << RAD_SH;
			end

			if (degree_mode) begin
				rad_s2 <= RW'((prod_s1 + DEG_RND) >> DEG_SH);
			end else begin
				rad_s2 <= RW'(prod_s1);
			end

			if (rad_s2 > PI_R) begin
				rad_s3 <= (rad_s2 >= TWOPI_R) ? '0 : (TWOPI_R - rad_s2);
			end else begin
				rad_s3 <= rad_s2;
			end

			rad_s4 <= (rad_s3 > HALFPI_R) ? (PI_R - rad_s3) : rad_s3;

			if (ctl_s4.neg) begin
				z_s5 <= -$signed(sdr_pkg::Z_W'(rad_s4));
			end else begin
				z_s5 <= $signed(sdr_pkg::Z_W'(rad_s4));
			end
		end
	end

	assign ctl_o = ctl_s5;
	assign z_o   = z_s5;

endmodule

// File: rtl/sdr_cordic.sv
// Unrolled rotation-mode CORDIC with one iteration per stage, then rounding and saturation.
`timescale 1ns / 1ps

module sdr_cordic #(
	parameter int SINE_FRAC_BITS = sdr_pkg::SINE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES  = sdr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  sdr_pkg::sdr_ctl_t                 ctl_i,
	input  logic signed [sdr_pkg::Z_W-1:0]    z_i,
	output sdr_pkg::sdr_ctl_t                 ctl_o,
	output logic signed [sdr_pkg::SINE_W-1:0] sine_o
);

	localparam int XW = sdr_pkg::XY_W;
	localparam int ZW = sdr_pkg::Z_W;
	localparam int RND_SH = 30 - SINE_FRAC_BITS;
	localparam logic signed [XW-1:0] ONE_P = XW'(64'd1 << SINE_FRAC_BITS);
	localparam logic signed [XW-1:0] ONE_N = -ONE_P;

	logic signed [XW-1:0] x_s [0:CORDIC_STAGES];
	logic signed [XW-1:0] y_s [0:CORDIC_STAGES];
	logic signed [ZW-1:0] z_s [0:CORDIC_STAGES];
	sdr_pkg::sdr_ctl_t    ctl_s [0:CORDIC_STAGES];

	logic signed [XW-1:0]             rnd;
	logic signed [XW-1:0]             sat;
	sdr_pkg::sdr_ctl_t                ctl_so;
	logic signed [sdr_pkg::SINE_W-1:0] sine_so;

	assign x_s[0]   = XW'(sdr_pkg::GAIN_Q30);
	assign y_s[0]   = '0;
	assign z_s[0]   = z_i;
	assign ctl_s[0] = ctl_i;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN = ZW'(sdr_pkg::atan_q32(k));

		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;

		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[k][ZW-1]) begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - ATAN;
				end else begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + ATAN;
				end
			end
		end
	end

	if (RND_SH > 0) begin : g_round
		localparam logic signed [XW-1:0] HALF_LSB = XW'(64'd1 << (RND_SH - 1));
		assign rnd = (y_s[CORDIC_STAGES] + HALF_LSB) >>> RND_SH;
	end else begin : g_keep
		assign rnd = y_s[CORDIC_STAGES];
	end

	always_comb begin
		if (rnd > ONE_P) begin
			sat = ONE_P;
		end else if (rnd < ONE_N) begin
			sat = ONE_N;
		end else begin
			sat = rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_so <= '0;
		end else if (en) begin
			ctl_so <= ctl_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_so <= ctl_s[CORDIC_STAGES].zero ? '0 : sat[sdr_pkg::SINE_W-1:0];
		end
	end

	assign ctl_o  = ctl_so;
	assign sine_o = sine_so;

endmodule

// File: rtl/sine_degree_radian_unit.sv
// Top level of the pipelined sine unit: mode register, pipeline and output skid register.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+---------------------------------
//   input    | in_valid / in_ready       | angle (signed Q16.16)
//   output   | out_valid / out_ready     | sine_value (signed Q2.30)
//   config   | cfg_wr_en (no wait)       | cfg_wr_data (degree mode bit)
//
// One request enters per clock while in_ready is high. A request passes through the modulo
// compare-subtract stages (REDUCE_STEPS of them, 13 at 16 fraction bits), the conversion
// stages and the unrolled CORDIC stages.
// Reset clears all valid bits and the skid valid flag and sets degree mode.
// When the output stalls, the result moves into the skid register and the whole pipeline
// holds until it drains; in_ready is low only while the skid register is full.
`timescale 1ns / 1ps

module sine_degree_radian_unit #(
	parameter int ANGLE_FRAC_BITS = sdr_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int SINE_FRAC_BITS  = sdr_pkg::SINE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = sdr_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sdr_pkg::ANGLE_W-1:0] angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sdr_pkg::SINE_W-1:0]  sine_value
);

	localparam logic signed [sdr_pkg::SINE_W-1:0] SINE_ONE =
		sdr_pkg::SINE_W'(64'd1 << SINE_FRAC_BITS);

	logic                              degree_mode_q;
	logic                              pipe_en;
	sdr_pkg::sdr_ctl_t                 red_ctl;
	logic [sdr_pkg::MAG_W-1:0]         red_mag;
	sdr_pkg::sdr_ctl_t                 cnv_ctl;
	logic signed [sdr_pkg::Z_W-1:0]    cnv_z;
	sdr_pkg::sdr_ctl_t                 last_ctl;
	logic signed [sdr_pkg::SINE_W-1:0] last_sine;
	logic                              skid_valid_q;
	logic signed [sdr_pkg::SINE_W-1:0] skid_sine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			degree_mode_q <= cfg_wr_data;
		end
	end

	assign pipe_en  = !skid_valid_q;
	assign in_ready = !skid_valid_q;

	sdr_reduce #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (pipe_en),
		.degree_mode(degree_mode_q),
		.in_valid   (in_valid),
		.angle      (angle),
		.ctl_o      (red_ctl),
		.mag_o      (red_mag)
	);

	sdr_convert #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_convert (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (pipe_en),
		.degree_mode(degree_mode_q),
		.ctl_i      (red_ctl),
		.mag_i      (red_mag),
		.ctl_o      (cnv_ctl),
		.z_o        (cnv_z)
	);

	sdr_cordic #(
		.SINE_FRAC_BITS(SINE_FRAC_BITS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (pipe_en),
		.ctl_i (cnv_ctl),
		.z_i   (cnv_z),
		.ctl_o (last_ctl),
		.sine_o(last_sine)
	);

	// A result the consumer does not take is parked here while the pipeline holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (last_ctl.valid && !out_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_sine_q <= last_sine;
		end
	end

	assign out_valid  = skid_valid_q || last_ctl.valid;
	assign sine_value = skid_valid_q ? skid_sine_q : last_sine;

	a_zero_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(last_ctl.valid && last_ctl.zero) |-> (last_sine == '0))
		else $error("forced zero result is not zero");

	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_ctl.valid |-> ((last_sine <= SINE_ONE) && (last_sine >= -SINE_ONE)))
		else $error("sine result outside plus or minus one");

	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(last_ctl.valid && !out_ready))
		else $error("skid register loaded without a stalled result");

	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> ($stable(last_ctl) && $stable(last_sine)))
		else $error("pipeline advanced while the skid register was full");

endmodule
